// ----- design/bsam_pkg.sv -----
// Package for the bank switch address mapper: payload types, region codes and constants.
package bsam_pkg;

    typedef struct packed {
        logic        kind;
        logic [15:0] address;
        logic [7:0]  data;
    } bsam_in_t;

    typedef struct packed {
        logic [3:0]  region;
        logic [22:0] physical_offset;
        logic        memory_write;
    } bsam_out_t;

    localparam logic [3:0] REGION_ROM      = 4'd0;
    localparam logic [3:0] REGION_VRAM     = 4'd1;
    localparam logic [3:0] REGION_CRAM     = 4'd2;
    localparam logic [3:0] REGION_WRAM     = 4'd3;
    localparam logic [3:0] REGION_OAM      = 4'd4;
    localparam logic [3:0] REGION_UNUSABLE = 4'd5;
    localparam logic [3:0] REGION_IO       = 4'd6;
    localparam logic [3:0] REGION_HRAM     = 4'd7;
    localparam logic [3:0] REGION_IE       = 4'd8;
    localparam logic [3:0] REGION_UNMAPPED = 4'd9;

    localparam logic [7:0] CFG_ROM_BANK_CODE  = 8'd0;
    localparam logic [7:0] CFG_RAM_BANK_COUNT = 8'd1;

    localparam logic       KIND_WRITE = 1'b1;

    localparam logic [15:0] ADDR_ROM_HIGH  = 16'h4000;
    localparam logic [15:0] ADDR_VRAM      = 16'h8000;
    localparam logic [15:0] ADDR_CRAM      = 16'hA000;
    localparam logic [15:0] ADDR_WRAM      = 16'hC000;
    localparam logic [15:0] ADDR_ECHO      = 16'hE000;
    localparam logic [15:0] ADDR_OAM       = 16'hFE00;
    localparam logic [15:0] ADDR_OAM_LAST  = 16'hFE9F;
    localparam logic [15:0] ADDR_UNUSABLE  = 16'hFEA0;
    localparam logic [15:0] ADDR_IO        = 16'hFF00;
    localparam logic [15:0] ADDR_IO_LAST   = 16'hFF7F;
    localparam logic [15:0] ADDR_HRAM_LAST = 16'hFFFE;

    localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
    localparam logic [4:0] ROM_BANK_MASK  = 5'b11111;

endpackage

// ----- design/bank_switch_address_mapper.sv -----
// Bank switch address mapper: cartridge bank registers and CPU bus address decode.
//
// Usage:
//  - s_ channel carries one CPU bus access per transaction (kind, address, data).
//  - m_ channel returns one result per access: region, physical offset and the
//    memory write strobe, in access order.
//  - cfg channel writes the ROM size code (index 0) and ram_bank_count (index 1);
//    cfg_ready is always high. Write it only while no access is in flight.
//  - The result is registered: an access accepted in one cycle is offered on m_
//    in the next. Throughput is one access per cycle while m_ready is high, set by
//    the single decode stage that feeds the result register.
//  - Writes below 0x8000 update the bank registers at the accepting edge, so
//    the next access already sees the new banks.
//  - When the receiver stalls, the result register holds its transaction and
//    s_ready stays high only if that result is taken in the same cycle.
//  - Reset (aresetn low, synchronous) empties the result register, clears both
//    configuration registers, disables cart RAM, selects ROM bank 1, low bank 0,
//    RAM bank 0 and simple banking mode.
module bank_switch_address_mapper
    import bsam_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic [7:0] cfg_data,

    input  logic       s_valid,
    output logic       s_ready,
    input  bsam_in_t   s_payload,

    output logic       m_valid,
    input  logic       m_ready,
    output bsam_out_t  m_payload
);

    logic [3:0] rom_bank_code_reg;
    logic [4:0] ram_bank_count_reg;
    logic       ram_enable_reg,      ram_enable_next;
    logic [8:0] switch_rom_bank_reg, switch_rom_bank_next;
    logic [8:0] low_rom_bank_reg,    low_rom_bank_next;
    logic [1:0] cart_ram_bank_reg,   cart_ram_bank_next;
    logic       advanced_mode_reg,   advanced_mode_next;
    logic       m_valid_reg;
    bsam_out_t  m_payload_reg,       m_payload_next;

    logic       in_accept;
    logic       wr;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [4:0]  low_bits;
    logic [1:0]  upper_bits;
    logic [7:0]  unusable_off;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    assign wr   = (s_payload.kind == KIND_WRITE);
    assign addr = s_payload.address;
    assign data = s_payload.data;
    assign upper_bits   = data[1:0];
    assign unusable_off = addr[7:0] - ADDR_UNUSABLE[7:0];

    always_comb begin
        // bank number bits kept by a 0x2000 write, masked for small ROMs; zero becomes 1
        if (rom_bank_code_reg <= 4'd4) begin
            low_bits = data[4:0] & (ROM_BANK_MASK >> (3'd4 - rom_bank_code_reg[2:0]));
        end else begin
            low_bits = data[4:0] & ROM_BANK_MASK;
        end
        if (low_bits == 5'd0) begin
            low_bits = 5'd1;
        end
    end

    // bank register update, only for writes below 0x8000
    always_comb begin
        ram_enable_next      = ram_enable_reg;
        switch_rom_bank_next = switch_rom_bank_reg;
        low_rom_bank_next    = low_rom_bank_reg;
        cart_ram_bank_next   = cart_ram_bank_reg;
        advanced_mode_next   = advanced_mode_reg;
        if (in_accept && wr && !addr[15]) begin
            case (addr[14:13])
                2'd0: begin
                    ram_enable_next = (data[3:0] == RAM_ENABLE_KEY);
                end
                2'd1: begin
                    if (rom_bank_code_reg == 4'd0) begin
                        switch_rom_bank_next = switch_rom_bank_reg;
                    end else if (rom_bank_code_reg <= 4'd4) begin
                        switch_rom_bank_next = {4'd0, low_bits};
                    end else begin
                        switch_rom_bank_next = {2'd0, switch_rom_bank_reg[6:5], low_bits};
                    end
                end
                2'd2: begin
                    if (rom_bank_code_reg >= 4'd5) begin
                        switch_rom_bank_next = {2'd0, upper_bits, switch_rom_bank_reg[4:0]};
                        low_rom_bank_next    = {2'd0, upper_bits, 5'd0};
                    end
                    if (ram_bank_count_reg >= 5'd4) begin
                        cart_ram_bank_next = upper_bits;
                    end
                end
                default: begin
                    advanced_mode_next = data[0];
                end
            endcase
        end
    end

    // region decode and offset
    always_comb begin
        m_payload_next.region          = REGION_IE;
        m_payload_next.physical_offset = 23'd0;
        m_payload_next.memory_write    = wr;
        if (addr < ADDR_VRAM) begin
            m_payload_next.region = REGION_ROM;
            if (wr) begin
                m_payload_next.memory_write = 1'b0;
            end else if (addr < ADDR_ROM_HIGH) begin
                if (advanced_mode_reg) begin
                    m_payload_next.physical_offset = {low_rom_bank_reg, addr[13:0]};
                end else begin
                    m_payload_next.physical_offset = {9'd0, addr[13:0]};
                end
            end else begin
                m_payload_next.physical_offset = {switch_rom_bank_reg, addr[13:0]};
            end
        end else if (addr < ADDR_CRAM) begin
            m_payload_next.region          = REGION_VRAM;
            m_payload_next.physical_offset = {10'd0, addr[12:0]};
        end else if (addr < ADDR_WRAM) begin
            if (ram_enable_reg) begin
                m_payload_next.region = REGION_CRAM;
                if (advanced_mode_reg) begin
                    m_payload_next.physical_offset = {8'd0, cart_ram_bank_reg, addr[12:0]};
                end else begin
                    m_payload_next.physical_offset = {10'd0, addr[12:0]};
                end
            end else begin
                m_payload_next.region       = REGION_UNMAPPED;
                m_payload_next.memory_write = 1'b0;
            end
        end else if (addr < ADDR_OAM) begin
            // work RAM and its echo share the low 13 address bits
            m_payload_next.region          = REGION_WRAM;
            m_payload_next.physical_offset = {10'd0, addr[12:0]};
        end else if (addr <= ADDR_OAM_LAST) begin
            m_payload_next.region          = REGION_OAM;
            m_payload_next.physical_offset = {15'd0, addr[7:0]};
        end else if (addr < ADDR_IO) begin
            m_payload_next.region          = REGION_UNUSABLE;
            m_payload_next.physical_offset = {15'd0, unusable_off};
            m_payload_next.memory_write    = 1'b0;
        end else if (addr <= ADDR_IO_LAST) begin
            m_payload_next.region          = REGION_IO;
            m_payload_next.physical_offset = {16'd0, addr[6:0]};
        end else if (addr <= ADDR_HRAM_LAST) begin
            m_payload_next.region          = REGION_HRAM;
            m_payload_next.physical_offset = {16'd0, addr[6:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_bank_code_reg   <= 4'd0;
            ram_bank_count_reg  <= 5'd0;
            ram_enable_reg      <= 1'b0;
            switch_rom_bank_reg <= 9'd1;
            low_rom_bank_reg    <= 9'd0;
            cart_ram_bank_reg   <= 2'd0;
            advanced_mode_reg   <= 1'b0;
            m_valid_reg         <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_ROM_BANK_CODE:  rom_bank_code_reg  <= cfg_data[3:0];
                    CFG_RAM_BANK_COUNT: ram_bank_count_reg <= cfg_data[4:0];
                    default: ;
                endcase
            end
            ram_enable_reg      <= ram_enable_next;
            switch_rom_bank_reg <= switch_rom_bank_next;
            low_rom_bank_reg    <= low_rom_bank_next;
            cart_ram_bank_reg   <= cart_ram_bank_next;
            advanced_mode_reg   <= advanced_mode_next;
            if (in_accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            m_payload_reg <= m_payload_next;
        end
    end

endmodule
